FILE: design/sbi_pkg.sv
// shared control types for the segment/box intersection pipeline
`default_nettype none
package sbi_pkg;

  // control bits that travel with every beat through the pipeline
  typedef struct packed {
    logic valid;
    logic hit;
    logic vert;
  } sbi_ctl_t;

endpackage
`default_nettype wire

FILE: design/segment_box_intersection_core.sv
// top level: segment against axis-aligned box, hit flag and crossing point
`default_nettype none
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall   segment endpoints, box corner and size
//  out_     output     out_valid / out_stall hit flag, point x and y
//
//  one beat enters per cycle unless in_stall is high; the pipeline is made of
//  five geometry stages, COORD_BITS-1 divider stages and the output register
//  latency is set by the bit-per-stage quotient of the crossing point
//  rst_n is synchronous and clears only the valid bits
//  a stalled output freezes the whole pipeline; the input register still
//  takes a beat while it is empty
//
module segment_box_intersection_core #(
  parameter int COORD_BITS = 24
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  signed [COORD_BITS-1:0] in_start_x,
  input  wire  signed [COORD_BITS-1:0] in_start_y,
  input  wire  signed [COORD_BITS-1:0] in_end_x,
  input  wire  signed [COORD_BITS-1:0] in_end_y,
  input  wire  signed [COORD_BITS-1:0] in_box_left,
  input  wire  signed [COORD_BITS-1:0] in_box_top,
  input  wire  [COORD_BITS-2:0]        in_box_width,
  input  wire  [COORD_BITS-2:0]        in_box_height,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        out_hit,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y
);
  import sbi_pkg::*;

  localparam int N = COORD_BITS;

  // whole pipeline moves unless a finished beat is held at the output
  logic en;
  logic out_valid_r;

  assign en        = ~(out_valid_r & out_stall);
  assign out_valid = out_valid_r;

  sbi_ctl_t          g_ctl, d_ctl;
  logic [2*N-2:0]    g_dvd;
  logic [N:0]        g_dvs;
  logic signed [N:0] g_fix, g_base, d_fix, d_base;
  logic [N-2:0]      d_quo;

  sbi_geom #(.N(N)) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_box_left   (in_box_left),
    .in_box_top    (in_box_top),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .ctl_o         (g_ctl),
    .dvd_o         (g_dvd),
    .dvs_o         (g_dvs),
    .fix_o         (g_fix),
    .base_o        (g_base)
  );

  sbi_div #(.N(N)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (g_ctl),
    .dvd_i  (g_dvd),
    .dvs_i  (g_dvs),
    .fix_i  (g_fix),
    .base_i (g_base),
    .ctl_o  (d_ctl),
    .quo_o  (d_quo),
    .fix_o  (d_fix),
    .base_o (d_base)
  );

  // clamp an (N+2)-bit value to the signed coordinate range
  function automatic logic [N-1:0] sat_c(input logic [N+1:0] v);
    logic [N-1:0] r;
    if (v[N+1:N-1] == '0 || v[N+1:N-1] == '1) begin
      r = v[N-1:0];
    end else if (v[N+1]) begin
      r = {1'b1, {(N-1){1'b0}}};
    end else begin
      r = {1'b0, {(N-1){1'b1}}};
    end
    return r;
  endfunction

  // moving coordinate is edge start plus truncated quotient
  logic signed [N+1:0] mov;
  logic [N-1:0]        mov_c, fix_c;
  logic [N-1:0]        px_nxt, py_nxt;

  always_comb begin
    mov    = (N+2)'(d_base) + $signed((N+2)'(d_quo));
    mov_c  = sat_c(mov);
    fix_c  = sat_c((N+2)'(d_fix));
    px_nxt = '0;
    py_nxt = '0;
    if (d_ctl.hit) begin
      px_nxt = d_ctl.vert ? fix_c : mov_c;
      py_nxt = d_ctl.vert ? mov_c : fix_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_ctl.valid;
    end
    if (en) begin
      out_hit     <= d_ctl.hit;
      out_point_x <= px_nxt;
      out_point_y <= py_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/sbi_geom.sv
// geometry front end: edge choice, cross products and hit tests over five stages
`default_nettype none
module sbi_geom #(
  parameter int N = 24
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [N-1:0]        in_start_x,
  input  wire  [N-1:0]        in_start_y,
  input  wire  [N-1:0]        in_end_x,
  input  wire  [N-1:0]        in_end_y,
  input  wire  [N-1:0]        in_box_left,
  input  wire  [N-1:0]        in_box_top,
  input  wire  [N-2:0]        in_box_width,
  input  wire  [N-2:0]        in_box_height,
  output sbi_pkg::sbi_ctl_t   ctl_o,
  output logic [2*N-2:0]      dvd_o,
  output logic [N:0]          dvs_o,
  output logic signed [N:0]   fix_o,
  output logic signed [N:0]   base_o
);
  import sbi_pkg::*;

  localparam int PW = 2*N + 3;
  localparam int TW = 2*N + 4;
  localparam int LW = 2*N;
  localparam int DW = 2*N - 1;

  typedef struct packed {
    logic                rej;
    logic                dxpos;
    logic                dyneg;
    logic                dxz;
    logic                dyz;
    logic                hz;
    logic                wz;
    logic [N:0]          adx;
    logic [N:0]          ady;
    logic signed [N+1:0] cxv;
    logic signed [N+1:0] cyh;
    logic signed [N:0]   axv;
    logic signed [N:0]   ayh;
    logic signed [N:0]   lf;
    logic signed [N:0]   tp;
  } side_t;

  // stage 1: input capture
  logic                v1_r;
  logic signed [N-1:0] x1_r, y1_r, x2_r, y2_r, lf1_r, tp1_r;
  logic [N-2:0]        w1_r, h1_r;
  logic                ld1;

  assign ld1      = en | ~v1_r;
  assign in_stall = ~ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_valid;
    end
    if (ld1) begin
      x1_r  <= in_start_x;
      y1_r  <= in_start_y;
      x2_r  <= in_end_x;
      y2_r  <= in_end_y;
      lf1_r <= in_box_left;
      tp1_r <= in_box_top;
      w1_r  <= in_box_width;
      h1_r  <= in_box_height;
    end
  end

  // stage 2: edges, deltas, offsets
  logic signed [N:0]   x1e, y1e, x2e, y2e, lfe, tpe, rt, bt, dx, dy;
  logic signed [N+1:0] cyv_nxt, cxh_nxt;
  side_t               side_nxt;

  always_comb begin
    x1e = {x1_r[N-1], x1_r};
    y1e = {y1_r[N-1], y1_r};
    x2e = {x2_r[N-1], x2_r};
    y2e = {y2_r[N-1], y2_r};
    lfe = {lf1_r[N-1], lf1_r};
    tpe = {tp1_r[N-1], tp1_r};
    rt  = lfe + $signed({2'b00, w1_r});
    bt  = tpe + $signed({2'b00, h1_r});
    dx  = x2e - x1e;
    dy  = y2e - y1e;
    side_nxt.rej   = (x1e < lfe && x2e < lfe) || (x1e > rt && x2e > rt) ||
                     (y1e < tpe && y2e < tpe) || (y1e > bt && y2e > bt);
    side_nxt.dxz   = (dx == '0);
    side_nxt.dyz   = (dy == '0);
    side_nxt.dxpos = ~dx[N] & ~side_nxt.dxz;
    side_nxt.dyneg = dy[N];
    side_nxt.hz    = (h1_r == '0);
    side_nxt.wz    = (w1_r == '0);
    side_nxt.adx   = dx[N] ? (N+1)'(-dx) : dx;
    side_nxt.ady   = dy[N] ? (N+1)'(-dy) : dy;
    side_nxt.axv   = side_nxt.dxpos ? lfe : rt;
    side_nxt.ayh   = (~dy[N] && dy != '0) ? tpe : bt;
    side_nxt.cxv   = {x1e[N], x1e} - {side_nxt.axv[N], side_nxt.axv};
    side_nxt.cyh   = {y1e[N], y1e} - {side_nxt.ayh[N], side_nxt.ayh};
    side_nxt.lf    = lfe;
    side_nxt.tp    = tpe;
    cyv_nxt        = {y1e[N], y1e} - {tpe[N], tpe};
    cxh_nxt        = {x1e[N], x1e} - {lfe[N], lfe};
  end

  logic                v2_r;
  side_t               side2_r;
  logic signed [N:0]   dx2_r, dy2_r;
  logic signed [N+1:0] cyv2_r, cxh2_r;
  logic [N-2:0]        w2_r, h2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      side2_r <= side_nxt;
      dx2_r   <= dx;
      dy2_r   <= dy;
      cyv2_r  <= cyv_nxt;
      cxh2_r  <= cxh_nxt;
      w2_r    <= w1_r;
      h2_r    <= h1_r;
    end
  end

  // stage 3: products
  logic signed [PW-1:0] p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  logic [LW-1:0]        limv_nxt, limh_nxt;

  assign p1_nxt   = side2_r.cxv * dy2_r;
  assign p2_nxt   = cyv2_r * dx2_r;
  assign p3_nxt   = cxh2_r * dy2_r;
  assign p4_nxt   = side2_r.cyh * dx2_r;
  assign limv_nxt = h2_r * side2_r.adx;
  assign limh_nxt = w2_r * side2_r.ady;

  logic                 v3_r;
  side_t                side3_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic [LW-1:0]        limv3_r, limh3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      side3_r <= side2_r;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      p3_r    <= p3_nxt;
      p4_r    <= p4_nxt;
      limv3_r <= limv_nxt;
      limh3_r <= limh_nxt;
    end
  end

  // stage 4: edge parameter numerators
  logic signed [TW-1:0] tnv_nxt, tnh_nxt;

  assign tnv_nxt = TW'(p1_r) - TW'(p2_r);
  assign tnh_nxt = TW'(p3_r) - TW'(p4_r);

  logic                 v4_r;
  side_t                side4_r;
  logic signed [TW-1:0] tnv4_r, tnh4_r;
  logic [LW-1:0]        limv4_r, limh4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      side4_r <= side3_r;
      tnv4_r  <= tnv_nxt;
      tnh4_r  <= tnh_nxt;
      limv4_r <= limv3_r;
      limh4_r <= limh3_r;
    end
  end

  // stage 5: range tests and edge select
  logic signed [TW-1:0]  tnvp, tnhp;
  logic signed [N+2:0]   cxp, cyp;
  logic                  vhit, hhit;
  sbi_ctl_t              ctl_nxt;
  logic [DW-1:0]         dvd_nxt;
  logic [N:0]            dvs_nxt;
  logic signed [N:0]     fix_nxt, base_nxt;

  always_comb begin
    // normalize so the cross product is positive
    tnvp = side4_r.dxpos ? -tnv4_r : tnv4_r;
    cxp  = side4_r.dxpos ? -(N+3)'(side4_r.cxv) : (N+3)'(side4_r.cxv);
    tnhp = side4_r.dyneg ? -tnh4_r : tnh4_r;
    cyp  = side4_r.dyneg ? (N+3)'(side4_r.cyh) : -(N+3)'(side4_r.cyh);
    vhit = ~side4_r.hz && ~side4_r.dxz &&
           ~tnvp[TW-1] && (tnvp <= $signed(TW'(limv4_r))) &&
           ~cxp[N+2] && (cxp <= $signed((N+3)'(side4_r.adx)));
    hhit = ~side4_r.wz && ~side4_r.dyz &&
           ~tnhp[TW-1] && (tnhp <= $signed(TW'(limh4_r))) &&
           ~cyp[N+2] && (cyp <= $signed((N+3)'(side4_r.ady)));
    ctl_nxt.valid = v4_r;
    ctl_nxt.vert  = vhit;
    ctl_nxt.hit   = ~side4_r.rej & (vhit | hhit);
    dvd_nxt  = vhit ? tnvp[DW-1:0] : tnhp[DW-1:0];
    dvs_nxt  = vhit ? side4_r.adx : side4_r.ady;
    fix_nxt  = vhit ? side4_r.axv : side4_r.ayh;
    base_nxt = vhit ? side4_r.tp : side4_r.lf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o.valid <= ctl_nxt.valid;
    end
    if (en) begin
      ctl_o.hit  <= ctl_nxt.hit;
      ctl_o.vert <= ctl_nxt.vert;
      dvd_o      <= dvd_nxt;
      dvs_o      <= dvs_nxt;
      fix_o      <= fix_nxt;
      base_o     <= base_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/sbi_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module sbi_div #(
  parameter int N = 24
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire sbi_pkg::sbi_ctl_t ctl_i,
  input  wire  [2*N-2:0]      dvd_i,
  input  wire  [N:0]          dvs_i,
  input  wire  signed [N:0]   fix_i,
  input  wire  signed [N:0]   base_i,
  output sbi_pkg::sbi_ctl_t   ctl_o,
  output logic [N-2:0]        quo_o,
  output logic signed [N:0]   fix_o,
  output logic signed [N:0]   base_o
);
  import sbi_pkg::*;

  localparam int DW = 2*N - 1;
  localparam int Q  = N - 1;

  logic [DW-1:0]     rem_r  [Q];
  logic [Q-1:0]      q_r    [Q];
  logic [N:0]        dvs_r  [Q];
  logic signed [N:0] fix_r  [Q];
  logic signed [N:0] base_r [Q];
  sbi_ctl_t          ctl_r  [Q];

  logic [DW-1:0]     rem_s  [Q];
  logic [Q-1:0]      q_s    [Q];
  logic [N:0]        dvs_s  [Q];
  logic signed [N:0] fix_s  [Q];
  logic signed [N:0] base_s [Q];
  sbi_ctl_t          ctl_s  [Q];

  logic [DW-1:0]     rem_nxt [Q];
  logic [Q-1:0]      q_nxt   [Q];
  logic [DW-1:0]     sh;

  always_comb begin
    rem_s[0]  = dvd_i;
    q_s[0]    = '0;
    dvs_s[0]  = dvs_i;
    fix_s[0]  = fix_i;
    base_s[0] = base_i;
    ctl_s[0]  = ctl_i;
    for (int j = 1; j < Q; j++) begin
      rem_s[j]  = rem_r[j-1];
      q_s[j]    = q_r[j-1];
      dvs_s[j]  = dvs_r[j-1];
      fix_s[j]  = fix_r[j-1];
      base_s[j] = base_r[j-1];
      ctl_s[j]  = ctl_r[j-1];
    end
  end

  // stage j decides quotient bit Q-1-j
  always_comb begin
    sh = '0;
    for (int j = 0; j < Q; j++) begin
      sh = DW'(dvs_s[j]) << (Q - 1 - j);
      if (rem_s[j] >= sh) begin
        rem_nxt[j] = rem_s[j] - sh;
        q_nxt[j]   = q_s[j] | (Q'(1) << (Q - 1 - j));
      end else begin
        rem_nxt[j] = rem_s[j];
        q_nxt[j]   = q_s[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < Q; j++) begin
      if (!rst_n) begin
        ctl_r[j].valid <= 1'b0;
      end else if (en) begin
        ctl_r[j].valid <= ctl_s[j].valid;
      end
      if (en) begin
        ctl_r[j].hit  <= ctl_s[j].hit;
        ctl_r[j].vert <= ctl_s[j].vert;
        rem_r[j]      <= rem_nxt[j];
        q_r[j]        <= q_nxt[j];
        dvs_r[j]      <= dvs_s[j];
        fix_r[j]      <= fix_s[j];
        base_r[j]     <= base_s[j];
      end
    end
  end

  assign ctl_o  = ctl_r[Q-1];
  assign quo_o  = q_r[Q-1];
  assign fix_o  = fix_r[Q-1];
  assign base_o = base_r[Q-1];

endmodule
`default_nettype wire

FILE: test/sbi_checker.sv
// checker: watches both channels, predicts segment/box crossings, compares results
`timescale 1ns / 100ps
module sbi_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire signed [23:0] in_start_x,
  input  wire signed [23:0] in_start_y,
  input  wire signed [23:0] in_end_x,
  input  wire signed [23:0] in_end_y,
  input  wire signed [23:0] in_box_left,
  input  wire signed [23:0] in_box_top,
  input  wire        [22:0] in_box_width,
  input  wire        [22:0] in_box_height,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire               out_hit,
  input  wire signed [23:0] out_point_x,
  input  wire signed [23:0] out_point_y,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic              hit;
    logic signed [23:0] px;
    logic signed [23:0] py;
  } crossing_t;

  crossing_t crossings_due[$];

  function automatic bit in_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  // one box edge from (ax, ay), vertical edge runs (0, len), horizontal (len, 0)
  function automatic bit edge_cross(bit vertical, longint ax, longint ay, longint len,
                                    longint px, longint py, longint dx, longint dy,
                                    output longint ox, output longint oy);
    longint bx, by, cr, cx, cy, tn, un;
    bx = vertical ? 0 : len;
    by = vertical ? len : 0;
    cr = bx * dy - by * dx;
    ox = 0;
    oy = 0;
    if (cr == 0) return 0;
    cx = px - ax;
    cy = py - ay;
    tn = cx * dy - cy * dx;
    if (!in_unit(tn, cr)) return 0;
    un = cx * by - cy * bx;
    if (!in_unit(un, cr)) return 0;
    // longint division truncates toward zero
    if (vertical) begin
      ox = ax;
      oy = ay + tn / (-dx);
    end else begin
      ox = ax + tn / dy;
      oy = ay;
    end
    return 1;
  endfunction

  function automatic crossing_t predict_crossing();
    longint x1, y1, x2, y2, lf, tp, w, h, rt, bt, dx, dy, ox, oy;
    crossing_t c;
    x1 = in_start_x; y1 = in_start_y; x2 = in_end_x; y2 = in_end_y;
    lf = in_box_left; tp = in_box_top;
    w = in_box_width; h = in_box_height;
    rt = lf + w; bt = tp + h;
    dx = x2 - x1; dy = y2 - y1;
    c.hit = 0; ox = 0; oy = 0;
    if (!((x1 < lf && x2 < lf) || (x1 > rt && x2 > rt) ||
          (y1 < tp && y2 < tp) || (y1 > bt && y2 > bt))) begin
      c.hit = edge_cross(1, dx > 0 ? lf : rt, tp, h, x1, y1, dx, dy, ox, oy);
      if (!c.hit)
        c.hit = edge_cross(0, lf, dy > 0 ? tp : bt, w, x1, y1, dx, dy, ox, oy);
    end
    if (!c.hit) begin
      ox = 0;
      oy = 0;
    end
    if (ox > 8388607) ox = 8388607;
    if (ox < -8388608) ox = -8388608;
    if (oy > 8388607) oy = 8388607;
    if (oy < -8388608) oy = -8388608;
    c.px = ox[23:0];
    c.py = oy[23:0];
    return c;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    crossing_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) crossings_due.push_back(predict_crossing());
      if (out_valid && !out_stall) begin
        if (crossings_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected beat: hit %0b x %0d y %0d",
                                         out_hit, out_point_x, out_point_y);
        end else begin
          e = crossings_due.pop_front();
          if (e.hit !== out_hit || e.px !== out_point_x || e.py !== out_point_y) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected hit %0b x %0d y %0d, got hit %0b x %0d y %0d",
                       e.hit, e.px, e.py, out_hit, out_point_x, out_point_y);
          end
        end
      end
      pending = crossings_due.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// testbench top: stimulus, idling phases and verdict for the intersection core
`timescale 1ns / 100ps
module tb_top;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic out_stall = 0;
  logic signed [23:0] in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic signed [23:0] in_box_left = 0, in_box_top = 0;
  logic [22:0] in_box_width = 0, in_box_height = 0;
  wire in_stall, out_valid, out_hit;
  wire signed [23:0] out_point_x, out_point_y;
  int fail_count, pending;

  // idling percentages, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  bit hold_off_go = 0;
  bit hold_off_seen = 0;

  always #4 clk = ~clk;

  segment_box_intersection_core uut (.*);
  sbi_checker chk (.*);

  // receiver side: random stall, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_off_go && !hold_off_seen) begin
      hold_off_seen <= 1;
      hold_off_cycles <= 200;
      out_stall <= 1;
    end else if (hold_off_cycles > 0) begin
      out_stall <= 1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else
      out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic signed [23:0] rnd_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(4095))) - 24'sd2048;
      default: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
    endcase
  endfunction

  // one beat: offer it, hold it until accepted
  task automatic send_query(logic signed [23:0] sx, sy, ex, ey, bl, bt,
                            logic [22:0] bw, bh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_start_x <= sx; in_start_y <= sy; in_end_x <= ex; in_end_y <= ey;
    in_box_left <= bl; in_box_top <= bt; in_box_width <= bw; in_box_height <= bh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly small boxes with segments near them so edges really get crossed
  task automatic send_random();
    int m;
    logic signed [23:0] bl, bt;
    logic [22:0] bw, bh;
    m = $urandom_range(9);
    if (m < 7) begin
      bl = $signed(24'($urandom_range(2047))) - 24'sd1024;
      bt = $signed(24'($urandom_range(2047))) - 24'sd1024;
      bw = 23'($urandom_range(1024));
      bh = 23'($urandom_range(1024));
      send_query(rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1), bl, bt, bw, bh);
    end else if (m < 9) begin
      send_query(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                 rnd_coord(0), rnd_coord(0), 23'($urandom), 23'($urandom));
    end else begin
      send_query(rnd_coord(2), rnd_coord(2), rnd_coord(2), rnd_coord(2),
                 rnd_coord(2), rnd_coord(2), $urandom_range(1) ? 23'h7fffff : 23'h0,
                 $urandom_range(1) ? 23'h7fffff : 23'h0);
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: left and right edge hits, top and bottom hits, rejects,
    // degenerate segment, zero-size box, collinear edge, corner, extremes
    send_query(0, 512, 2048, 512, 256, 0, 1024, 1024);
    send_query(2048, 512, 0, 512, 256, 0, 1024, 1024);
    send_query(512, -256, 600, 2048, 256, 0, 1024, 1024);
    send_query(600, 2048, 512, -256, 256, 0, 1024, 1024);
    send_query(0, 0, 100, 100, 256, 0, 1024, 1024);
    send_query(4000, 0, 5000, 100, 256, 0, 1024, 1024);
    send_query(300, -50, 400, -10, 256, 0, 1024, 1024);
    send_query(300, 2000, 400, 3000, 256, 0, 1024, 1024);
    send_query(500, 500, 500, 500, 256, 0, 1024, 1024);
    send_query(0, 0, 100, 100, 50, 50, 0, 0);
    send_query(256, -100, 256, 2000, 256, 0, 1024, 1024);
    send_query(0, -100, 500, 2000, 256, 0, 1024, 1024);
    send_query(0, 0, 256, 0, 256, 0, 1024, 1024);
    send_query(-7, 3, 1001, 1003, 256, 0, 1024, 1024);
    send_query(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff,
               24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff);
    send_query(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000,
               24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff);
    send_query(24'h7fffff, 0, 24'h800000, 1, 0, 24'h800000, 23'h7fffff, 23'h7fffff);
    send_query(0, 24'h800000, 1, 24'h7fffff, 24'h800000, 0, 23'h7fffff, 23'h7fffff);
    send_query(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 0, 0);

    // idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 24) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 53 : 24) : 0;
      // long receiver hold-off in the unstalled phase, sender keeps going
      if (ph == 0) hold_off_go = 1;
      repeat (480) send_random();
    end
    in_valid <= 0;
    recv_stall_pct = 0;

    wait_cycles = 0;
    while ((pending > 0 || hold_off_cycles > 0) && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("segment_box_intersection_core verification clean");
    else
      $display("segment_box_intersection_core verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("segment_box_intersection_core verification failed");
    $finish;
  end

endmodule
